// ===== src/line_substring_matcher_macros.svh =====
// ----------------------------------------------------------------------------
// line_substring_matcher_macros
// Assertion macros used by the line controller module (lsm_ctrl).
// ----------------------------------------------------------------------------
`ifndef LINE_SUBSTRING_MATCHER_MACROS_SVH
`define LINE_SUBSTRING_MATCHER_MACROS_SVH

// same-cycle implication
`define LSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/lsm_pkg.sv =====
// ----------------------------------------------------------------------------
// lsm_pkg
// Types, constants and helpers shared by the line matcher modules.
// ----------------------------------------------------------------------------
package lsm_pkg;

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 64;
	localparam int PatRegBytes = 16;

	localparam logic [CfgIdxW-1:0] CFG_FOLD_CASE = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_INVERT = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_PATTERN_LENGTH = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_PATTERN_LOW = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_PATTERN_HIGH = 3'd4;

	localparam logic [7:0] CHAR_NL = 8'h0A;
	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	// per-byte strobes from the line controller to the cell row
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

	function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
		logic [7:0] r;
		r = c;
		if (ic && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

// ===== src/lsm_cell.sv =====
// ----------------------------------------------------------------------------
// lsm_cell
// One pattern position: holds the partial match that ends at this position.
// ----------------------------------------------------------------------------
module lsm_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lsm_pkg::cell_ctl_t ctl,
	input  logic               fold_en,
	input  logic [4:0]         pattern_length,
	input  logic [7:0]         pat_byte,
	input  logic [7:0]         fold_byte,
	input  logic               prev_match,
	input  logic               en_prev,
	input  logic               en_next,
	output logic               en,
	output logic               match_q,
	output logic               last_hit
);
	import lsm_pkg::*;

	localparam logic [6:0] IdxC = 7'(IDX);

	logic len_ok;
	logic eq;
	logic match_d;

	// position in use: inside the length and before the first zero pattern byte
	assign len_ok = {2'b00, pattern_length} > IdxC;
	assign en = en_prev && len_ok && (pat_byte != CHAR_NUL);
	assign eq = fold(pat_byte, fold_en) == fold_byte;
	assign match_d = prev_match && eq && en;

	// full match when the last position in use matches on this byte
	assign last_hit = ctl.shift && match_d && !en_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.clear) begin
			match_q <= 1'b0;
		end else if (ctl.shift) begin
			match_q <= match_d;
		end
	end

endmodule

// ===== src/lsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsm_ctrl
// Line controller: line length, line and match counters, result register.
// ----------------------------------------------------------------------------
`include "line_substring_matcher_macros.svh"

module lsm_ctrl #(
	parameter int LINE_BYTES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic [7:0]         data_byte,
	input  logic               any_hit,
	input  logic               empty_pattern,
	input  logic               invert_en,
	output lsm_pkg::cell_ctl_t cell_ctl,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               line_valid,
	output logic               line_selected,
	output logic [31:0]        line_num,
	output logic [31:0]        match_total,
	output logic               file_done
);
	import lsm_pkg::*;

	localparam int BW = (LINE_BYTES > 2) ? $clog2(LINE_BYTES) : 1;
	localparam logic [BW-1:0] LastCount = BW'(LINE_BYTES - 2);

	logic [BW-1:0] bytes_q;
	logic          found_q;
	logic          zero_q;
	logic [31:0]   line_q;
	logic [31:0]   count_q;
	logic          out_valid_q;

	logic        take;
	logic        is_byte;
	logic        is_eof;
	logic        searchable;
	logic        found_now;
	logic        line_end;
	logic        close;
	logic        sel;
	logic [31:0] count_new;

	assign in_ready = !out_valid_q || out_ready;
	assign take = in_valid && in_ready;
	assign is_byte = take && !mode;
	assign is_eof = take && mode;

	assign searchable = !zero_q && (data_byte != CHAR_NUL) && !empty_pattern;
	assign cell_ctl.shift = is_byte && searchable;
	assign cell_ctl.clear = close || is_eof;

	assign found_now = found_q || (cell_ctl.shift && any_hit);
	assign line_end = is_byte && (data_byte == CHAR_NL || bytes_q == LastCount);
	assign close = line_end || (is_eof && bytes_q != '0);
	assign sel = (found_now || empty_pattern) ^ invert_en;
	assign count_new = (sel && count_q != '1) ? count_q + 32'd1 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= '0;
			found_q <= 1'b0;
			zero_q <= 1'b0;
			line_q <= 32'd1;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (is_eof) begin
				bytes_q <= '0;
				found_q <= 1'b0;
				zero_q <= 1'b0;
				line_q <= 32'd1;
				count_q <= '0;
			end else if (line_end) begin
				bytes_q <= '0;
				found_q <= 1'b0;
				zero_q <= 1'b0;
				count_q <= count_new;
				if (line_q != '1) begin
					line_q <= line_q + 32'd1;
				end
			end else if (is_byte) begin
				bytes_q <= bytes_q + BW'(1);
				found_q <= found_now;
				zero_q <= zero_q || (data_byte == CHAR_NUL);
			end
			if (line_end || is_eof) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload: load only when a result is produced
	always_ff @(posedge clk) begin
		if (line_end || is_eof) begin
			line_valid <= close;
			line_selected <= close && sel;
			line_num <= close ? line_q : '0;
			match_total <= close ? count_new : count_q;
			file_done <= is_eof;
		end
	end

	assign out_valid = out_valid_q;

	`LSM_ASSERT_NEXT(a_eof_restart, is_eof, line_q == 32'd1 && count_q == '0 && bytes_q == '0, "counters not restarted after end of file")
	`LSM_ASSERT_NOW(a_len_bound, 1'b1, bytes_q <= LastCount, "line length past its limit")
	`LSM_ASSERT_NEXT(a_line_clear, line_end, bytes_q == '0 && !found_q && !zero_q, "line state kept after line end")
	`LSM_ASSERT_NOW(a_line_num, out_valid_q && line_valid, line_num != '0, "closed line without a number")

endmodule

// ===== src/line_substring_matcher.sv =====
// ----------------------------------------------------------------------------
// line_substring_matcher
// Fixed-string line search over a byte stream, one byte per item.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle; in_ready drops only while a result sits in
// the output register and out_ready is low. A row of PATTERN_MAX cells, one per
// pattern position, updates every partial match in the same cycle as the byte
// arrives, so a result (line close or end of file) appears at the output in the
// cycle after the byte or end-of-file item that causes it. Configuration
// writes are always taken (cfg_ready is high) and apply from the next byte.
module line_substring_matcher #(
	parameter int PATTERN_MAX = 16,
	parameter int LINE_BYTES = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         mode,
	input  logic [7:0]                   data_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         line_valid,
	output logic                         line_selected,
	output logic [31:0]                  line_num,
	output logic [31:0]                  match_total,
	output logic                         file_done,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lsm_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [lsm_pkg::CfgDataW-1:0] cfg_data
);
	import lsm_pkg::*;

	logic                fold_en_q;
	logic                invert_en_q;
	logic [4:0]          pattern_length_q;
	logic [CfgDataW-1:0] pat_low_q;
	logic [CfgDataW-1:0] pat_high_q;

	logic [7:0]             fold_byte;
	logic [PATTERN_MAX:0]   en_chain;
	logic [PATTERN_MAX:0]   match_chain;
	logic [PATTERN_MAX-1:0] hits;
	cell_ctl_t              cell_ctl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_en_q <= 1'b0;
			invert_en_q <= 1'b0;
			pattern_length_q <= '0;
			pat_low_q <= '0;
			pat_high_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FOLD_CASE: begin
					fold_en_q <= cfg_data[0];
				end
				CFG_INVERT: begin
					invert_en_q <= cfg_data[0];
				end
				CFG_PATTERN_LENGTH: begin
					pattern_length_q <= cfg_data[4:0];
				end
				CFG_PATTERN_LOW: begin
					pat_low_q <= cfg_data;
				end
				CFG_PATTERN_HIGH: begin
					pat_high_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign fold_byte = fold(data_byte, fold_en_q);
	assign en_chain[0] = 1'b1;
	assign match_chain[0] = 1'b1;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		logic [7:0] pbyte;
		logic       en_next;

		if (i < 8) begin : g_low
			assign pbyte = pat_low_q[8*i +: 8];
		end else if (i < PatRegBytes) begin : g_high
			assign pbyte = pat_high_q[8*(i-8) +: 8];
		end else begin : g_none
			assign pbyte = CHAR_NUL;
		end

		if (i == PATTERN_MAX - 1) begin : g_tail
			assign en_next = 1'b0;
		end else begin : g_mid
			assign en_next = en_chain[i+2];
		end

		lsm_cell #(
			.IDX(i)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctl           (cell_ctl),
			.fold_en       (fold_en_q),
			.pattern_length(pattern_length_q),
			.pat_byte      (pbyte),
			.fold_byte     (fold_byte),
			.prev_match    (match_chain[i]),
			.en_prev       (en_chain[i]),
			.en_next       (en_next),
			.en            (en_chain[i+1]),
			.match_q       (match_chain[i+1]),
			.last_hit      (hits[i])
		);
	end

	lsm_ctrl #(
		.LINE_BYTES(LINE_BYTES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.data_byte    (data_byte),
		.any_hit      (|hits),
		.empty_pattern(!en_chain[1]),
		.invert_en    (invert_en_q),
		.cell_ctl     (cell_ctl),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.line_valid   (line_valid),
		.line_selected(line_selected),
		.line_num     (line_num),
		.match_total  (match_total),
		.file_done    (file_done)
	);

endmodule
